FILE: rtl/core/fsms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsms_pkg;

	// Car travels between floors 1..FLOOR_COUNT.
	localparam int unsigned FLOOR_COUNT = 3;
	localparam int unsigned FLOOR_W     = 2;
	localparam int unsigned SENSOR_W    = 3;
	localparam int unsigned SPF_W       = 15;
	localparam int unsigned STEPS_W     = 16;
	localparam int unsigned PHASE_W     = 3;
	localparam int unsigned COIL_W      = 4;

	localparam logic [SPF_W-1:0]   SPF_RESET  = 15'd4096;
	localparam logic [FLOOR_W-1:0] FLOOR_ONE  = 2'd1;
	localparam logic [FLOOR_W-1:0] FLOOR_LAST = FLOOR_W'(FLOOR_COUNT);

	typedef enum logic {
		OP_MOVE = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		MOTION_STOP = 2'd0,
		MOTION_UP   = 2'd1,
		MOTION_DOWN = 2'd2
	} motion_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [FLOOR_W-1:0]  target_floor;
		logic [SENSOR_W-1:0] floor_sensors;
	} item_t;

	// Input stage contents handed to the step engine.
	typedef struct packed {
		logic  valid;
		item_t item;
	} stage_t;

	// Half-step coil patterns, bit0 is the first coil.
	function automatic logic [COIL_W-1:0] half_step_pattern(input logic [PHASE_W-1:0] phase);
		logic [COIL_W-1:0] pat;
		unique case (phase)
			3'd0: pat = 4'd1;
			3'd1: pat = 4'd3;
			3'd2: pat = 4'd2;
			3'd3: pat = 4'd6;
			3'd4: pat = 4'd4;
			3'd5: pat = 4'd12;
			3'd6: pat = 4'd8;
			3'd7: pat = 4'd9;
			default: pat = 4'd0;
		endcase
		return pat;
	endfunction

	// Lowest set sensor bit within the building wins; otherwise keep the floor.
	function automatic logic [FLOOR_W-1:0] sense_floor(input logic [SENSOR_W-1:0] sensors,
	                                                   input logic [FLOOR_W-1:0] cur);
		logic [FLOOR_W-1:0] res;
		res = cur;
		for (int f = FLOOR_COUNT; f >= 1; f--) begin
			if (sensors[f-1]) begin
				res = FLOOR_W'(f);
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fsms_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fsms_cmd_if;
	import fsms_pkg::*;

	logic                valid;
	logic                ready;
	logic                opcode;
	logic [FLOOR_W-1:0]  target_floor;
	logic [SENSOR_W-1:0] floor_sensors;

	modport source (output valid, output opcode, output target_floor, output floor_sensors,
	                input ready);
	modport sink (input valid, input opcode, input target_floor, input floor_sensors,
	              output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fsms_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fsms_rsp_if;
	import fsms_pkg::*;

	logic               valid;
	logic               ready;
	logic [COIL_W-1:0]  coil_pattern;
	logic [1:0]         motion;
	logic [FLOOR_W-1:0] floor_now;
	logic               door_request;
	logic               busy_res;

	modport source (output valid, output coil_pattern, output motion, output floor_now,
	                output door_request, output busy_res, input ready);
	modport sink (input valid, input coil_pattern, input motion, input floor_now,
	              input door_request, input busy_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/floor_stepper_move_sequencer_core.sv
// A command beat waits in the input register until the engine takes it; its result is then registered.
// One command beat per cycle while rsp.ready is high; the car state register set updates once per beat.
// The input and result registers hold the beats; cmd.ready is high when the input one is empty or taken.
// Reset: arst_n clears the car to floor one, stopped, phase zero, and sets steps per floor to 4096.
`timescale 1ns / 1ps
`default_nettype none

module floor_stepper_move_sequencer_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [fsms_pkg::SPF_W-1:0] cfg_wdata,
	fsms_cmd_if.sink                        cmd,
	fsms_rsp_if.source                      rsp
);
	import fsms_pkg::*;

	stage_t stage;
	logic   take;

	fsms_in_reg u_in_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.take   (take),
		.stage  (stage)
	);

	fsms_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stage     (stage),
		.take      (take),
		.rsp       (rsp)
	);

	// A door request always comes with the coils released and the car stopped.
	a_door_stops: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.door_request |-> !rsp.busy_res && (rsp.coil_pattern == '0)
		&& (rsp.motion == MOTION_STOP))
		else $error("door request while driving coils or busy");

	// Energized coils imply a direction is reported.
	a_coil_moves: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.coil_pattern != '0) |-> (rsp.motion != MOTION_STOP))
		else $error("coils driven while stopped");

	// A move in progress always reports its direction.
	a_busy_dir: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.busy_res |-> (rsp.motion == MOTION_UP) || (rsp.motion == MOTION_DOWN))
		else $error("busy without direction");

	// A taken beat always lands in the result register on the next edge.
	a_take_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> rsp.valid)
		else $error("taken beat produced no result");

endmodule

`default_nettype wire

FILE: rtl/core/fsms_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module fsms_in_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	fsms_cmd_if.sink             cmd,
	input  wire logic            take,
	output fsms_pkg::stage_t     stage
);
	import fsms_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	// The stage frees up when the engine takes its beat in the same cycle.
	assign cmd.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.opcode        <= opcode_t'(cmd.opcode);
			item_s1.target_floor  <= cmd.target_floor;
			item_s1.floor_sensors <= cmd.floor_sensors;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

endmodule

`default_nettype wire

FILE: rtl/core/fsms_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module fsms_engine (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [fsms_pkg::SPF_W-1:0] cfg_wdata,
	input  fsms_pkg::stage_t                stage,
	output logic                            take,
	fsms_rsp_if.source                      rsp
);
	import fsms_pkg::*;

	logic [SPF_W-1:0]   spf_q;
	logic [FLOOR_W-1:0] floor_q;
	logic [FLOOR_W-1:0] goal_q;
	logic               moving_q;
	logic               down_q;
	logic [STEPS_W-1:0] steps_q;
	logic [PHASE_W-1:0] phase_q;

	logic [FLOOR_W-1:0] floor_n;
	logic [FLOOR_W-1:0] goal_n;
	logic               moving_n;
	logic               down_n;
	logic [STEPS_W-1:0] steps_n;
	logic [PHASE_W-1:0] phase_n;

	logic [COIL_W-1:0]  coil_c;
	motion_t            motion_c;
	logic               door_c;

	logic [FLOOR_W-1:0] floor_gap;
	logic [STEPS_W-1:0] budget;
	logic [STEPS_W-1:0] steps_dec;
	logic               start;

	logic               rsp_valid_q;
	logic [COIL_W-1:0]  coil_q;
	motion_t            motion_q;
	logic [FLOOR_W-1:0] floor_now_q;
	logic               door_q;
	logic               busy_q;

	item_t it;
	assign it = stage.item;

	// The engine takes a beat when the result register is free or drains this cycle.
	assign take = stage.valid && (!rsp_valid_q || rsp.ready);

	// Floor distance is at most two, so the budget is the setting or twice it.
	assign floor_gap = (it.target_floor > floor_q) ? (it.target_floor - floor_q)
	                                               : (floor_q - it.target_floor);
	assign budget = (floor_gap == 2'd2) ? {spf_q, 1'b0} : {1'b0, spf_q};
	assign start  = !moving_q && (it.target_floor >= FLOOR_ONE)
	                && (it.target_floor <= FLOOR_LAST)
	                && (it.target_floor != floor_q) && (spf_q != '0);
	assign steps_dec = (steps_q != '0) ? (steps_q - STEPS_W'(1)) : steps_q;

	// Next state and result for the beat in the input stage.
	always_comb begin
		floor_n  = floor_q;
		goal_n   = goal_q;
		moving_n = moving_q;
		down_n   = down_q;
		steps_n  = steps_q;
		phase_n  = phase_q;
		coil_c   = '0;
		motion_c = MOTION_STOP;
		door_c   = 1'b0;
		if (it.opcode == OP_MOVE) begin
			if (start) begin
				goal_n   = it.target_floor;
				down_n   = it.target_floor < floor_q;
				steps_n  = budget;
				moving_n = 1'b1;
			end
			if (moving_n) begin
				motion_c = down_n ? MOTION_DOWN : MOTION_UP;
			end
		end else if (moving_q) begin
			floor_n = sense_floor(it.floor_sensors, floor_q);
			if (floor_n == goal_q) begin
				moving_n = 1'b0;
				steps_n  = '0;
				door_c   = 1'b1;
			end else begin
				coil_c   = half_step_pattern(phase_q);
				motion_c = down_q ? MOTION_DOWN : MOTION_UP;
				phase_n  = down_q ? (phase_q + PHASE_W'(1)) : (phase_q - PHASE_W'(1));
				steps_n  = steps_dec;
				if (steps_dec == '0) begin
					moving_n = 1'b0;
				end
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spf_q <= SPF_RESET;
		end else if (cfg_we) begin
			spf_q <= cfg_wdata;
		end
	end

	// Car state advances once per taken beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q  <= FLOOR_ONE;
			goal_q   <= FLOOR_ONE;
			moving_q <= 1'b0;
			down_q   <= 1'b0;
			steps_q  <= '0;
			phase_q  <= '0;
		end else if (take) begin
			floor_q  <= floor_n;
			goal_q   <= goal_n;
			moving_q <= moving_n;
			down_q   <= down_n;
			steps_q  <= steps_n;
			phase_q  <= phase_n;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (take) begin
			coil_q      <= coil_c;
			motion_q    <= motion_c;
			floor_now_q <= floor_n;
			door_q      <= door_c;
			busy_q      <= moving_n;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.coil_pattern = coil_q;
	assign rsp.motion       = motion_q;
	assign rsp.floor_now    = floor_now_q;
	assign rsp.door_request = door_q;
	assign rsp.busy_res     = busy_q;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

import fsms_pkg::*;

// One result beat as the block reports it.
typedef struct packed {
	logic [COIL_W-1:0]  coil;
	motion_t            motion;
	logic [FLOOR_W-1:0] floor_now;
	logic               door;
	logic               busy;
} car_status_t;

// Tracks the car, predicts every result beat and checks the block against it.
class car_scoreboard;
	logic [SPF_W-1:0]   floor_steps;
	logic [FLOOR_W-1:0] floor_reg;
	logic [FLOOR_W-1:0] goal_floor;
	logic               moving;
	logic               going_down;
	logic [STEPS_W-1:0] steps_left;
	logic [PHASE_W-1:0] phase;
	car_status_t        status_q[$];
	int unsigned        mismatches;
	bit                 failed;

	function new();
		floor_steps = SPF_RESET;
		floor_reg   = FLOOR_ONE;
		goal_floor  = FLOOR_ONE;
		moving      = 1'b0;
		going_down  = 1'b0;
		steps_left  = '0;
		phase       = '0;
		mismatches  = 0;
		failed      = 1'b0;
	endfunction

	// Half-step drive sequence, first coil in bit 0.
	function logic [COIL_W-1:0] coil_for_phase(input logic [PHASE_W-1:0] p);
		logic [COIL_W-1:0] c;
		case (p)
			3'd0: c = 4'b0001;
			3'd1: c = 4'b0011;
			3'd2: c = 4'b0010;
			3'd3: c = 4'b0110;
			3'd4: c = 4'b0100;
			3'd5: c = 4'b1100;
			3'd6: c = 4'b1000;
			default: c = 4'b1001;
		endcase
		return c;
	endfunction

	// Advances the car model by one accepted command beat and queues its status.
	function void note_cmd(input opcode_t op, input logic [FLOOR_W-1:0] tgt,
	                       input logic [SENSOR_W-1:0] sens);
		car_status_t      st;
		int unsigned      floor_gap;
		int unsigned      budget;
		bit               found;
		st        = '0;
		st.motion = MOTION_STOP;
		found     = 1'b0;
		if (op == OP_MOVE) begin
			if (!moving && tgt >= 1 && tgt <= FLOOR_COUNT && tgt != floor_reg) begin
				floor_gap = (tgt > floor_reg) ? (tgt - floor_reg) : (floor_reg - tgt);
				budget    = floor_steps * floor_gap;
				if (budget > 32'hFFFF) begin
					budget = 32'hFFFF;
				end
				if (budget != 0) begin
					goal_floor = tgt;
					going_down = (tgt < floor_reg);
					steps_left = budget[STEPS_W-1:0];
					moving     = 1'b1;
				end
			end
			if (moving) begin
				st.motion = going_down ? MOTION_DOWN : MOTION_UP;
			end
		end else if (moving) begin
			// The lowest lit sensor inside the building names the floor.
			for (int f = 1; f <= FLOOR_COUNT; f++) begin
				if (!found && sens[f-1]) begin
					floor_reg = FLOOR_W'(f);
					found     = 1'b1;
				end
			end
			if (floor_reg == goal_floor) begin
				moving     = 1'b0;
				steps_left = '0;
				st.door    = 1'b1;
			end else begin
				st.coil   = coil_for_phase(phase);
				st.motion = going_down ? MOTION_DOWN : MOTION_UP;
				phase     = going_down ? phase + 1'b1 : phase - 1'b1;
				if (steps_left != 0) begin
					steps_left = steps_left - 1'b1;
				end
				if (steps_left == 0) begin
					moving = 1'b0;
				end
			end
		end
		st.floor_now = floor_reg;
		st.busy      = moving;
		status_q.push_back(st);
	endfunction

	// Compares one result beat with the oldest prediction.
	function void check_status(input car_status_t got);
		car_status_t want;
		if (status_q.size() == 0) begin
			failed = 1'b1;
			mismatches++;
			if (mismatches <= 10) begin
				$display("unexpected result beat: coil=%0d motion=%0d floor=%0d door=%0b busy=%0b",
				         got.coil, got.motion, got.floor_now, got.door, got.busy);
			end
			return;
		end
		want = status_q.pop_front();
		if (got.coil !== want.coil || got.motion !== want.motion ||
		    got.floor_now !== want.floor_now || got.door !== want.door ||
		    got.busy !== want.busy) begin
			failed = 1'b1;
			mismatches++;
			if (mismatches <= 10) begin
				$display("status mismatch: expected coil=%0d motion=%0d floor=%0d door=%0b busy=%0b",
				         want.coil, want.motion, want.floor_now, want.door, want.busy);
				$display("                 actual   coil=%0d motion=%0d floor=%0d door=%0b busy=%0b",
				         got.coil, got.motion, got.floor_now, got.door, got.busy);
			end
		end
	endfunction

	function int pending();
		return status_q.size();
	endfunction
endclass

module tb_top;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [SPF_W-1:0] cfg_wdata;
	bit               steady;
	int unsigned      cycles;
	car_scoreboard    sb;

	fsms_cmd_if cmd_if ();
	fsms_rsp_if rsp_if ();

	floor_stepper_move_sequencer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_if),
		.rsp       (rsp_if)
	);

	// 50 MHz clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Result side stalls at random unless a steady stretch is running.
	always @(posedge clk) begin
		rsp_if.ready <= steady || ($urandom_range(0, 99) >= 37);
	end

	// Watch both handshakes; results are checked before the new command is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				sb.check_status({rsp_if.coil_pattern, motion_t'(rsp_if.motion), rsp_if.floor_now,
				                 rsp_if.door_request, rsp_if.busy_res});
			end
			if (cmd_if.valid && cmd_if.ready) begin
				sb.note_cmd(opcode_t'(cmd_if.opcode), cmd_if.target_floor, cmd_if.floor_sensors);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// Offers one command beat, with random gaps first, and waits for its acceptance.
	task automatic send_cmd(input opcode_t op, input logic [FLOOR_W-1:0] tgt,
	                        input logic [SENSOR_W-1:0] sens);
		while (!steady && $urandom_range(0, 99) < 37) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid         <= 1'b1;
		cmd_if.opcode        <= op;
		cmd_if.target_floor  <= tgt;
		cmd_if.floor_sensors <= sens;
		do begin
			@(posedge clk);
		end while (!cmd_if.ready);
	endtask

	// Stops sending and waits for every predicted result beat.
	// It first lets the last accepted command be noted, then waits for the pending ones.
	task automatic drain_results();
		cmd_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// Writes the per-floor step count once the car pipeline is empty.
	task automatic set_floor_steps(input logic [SPF_W-1:0] value);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we         <= 1'b0;
		sb.floor_steps = value;
	endtask

	// Mostly dark sensors, some single floor marks, some arbitrary patterns.
	function automatic logic [SENSOR_W-1:0] pick_sensors();
		int s;
		s = $urandom_range(0, 99);
		if (s < 65) begin
			return '0;
		end else if (s < 82) begin
			return 3'b001 << $urandom_range(0, 2);
		end
		return SENSOR_W'($urandom_range(0, 7));
	endfunction

	// One trip: a move request followed by a run of mostly ticks, or a stray beat.
	task automatic run_trip(output int sent);
		int n;
		sent = 0;
		if ($urandom_range(0, 99) < 8) begin
			send_cmd(opcode_t'($urandom_range(0, 1)), FLOOR_W'($urandom_range(0, 3)),
			         SENSOR_W'($urandom_range(0, 7)));
			sent = 1;
		end else begin
			send_cmd(OP_MOVE, ($urandom_range(0, 9) == 0) ? 2'd0 : FLOOR_W'($urandom_range(1, 3)),
			         SENSOR_W'($urandom_range(0, 7)));
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 99) < 5) begin
					send_cmd(OP_MOVE, FLOOR_W'($urandom_range(0, 3)), SENSOR_W'($urandom_range(0, 7)));
				end else begin
					send_cmd(OP_TICK, FLOOR_W'($urandom_range(0, 3)), pick_sensors());
				end
			end
			sent = n + 1;
		end
	endtask

	initial begin
		int               sent;
		int               quota;
		int               count;
		logic [SPF_W-1:0] spf;
		sb                   = new();
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		steady               = 1'b0;
		cycles               = 0;
		cmd_if.valid         = 1'b0;
		cmd_if.opcode        = OP_MOVE;
		cmd_if.target_floor  = '0;
		cmd_if.floor_sensors = '0;
		rsp_if.ready         = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default budget: up two floors, pass floor two, reach the goal.
		send_cmd(OP_MOVE, 2'd3, 3'b111);
		send_cmd(OP_TICK, 2'd0, 3'b000);
		send_cmd(OP_TICK, 2'd1, 3'b010);
		send_cmd(OP_MOVE, 2'd1, 3'b000);
		send_cmd(OP_TICK, 2'd2, 3'b110);
		send_cmd(OP_TICK, 2'd3, 3'b100);
		// Idle tick, request for the current floor and an out-of-range target.
		send_cmd(OP_TICK, 2'd3, 3'b111);
		send_cmd(OP_MOVE, 2'd3, 3'b000);
		send_cmd(OP_MOVE, 2'd0, 3'b101);
		// Down two floors, the car is marked at floor one.
		send_cmd(OP_MOVE, 2'd1, 3'b000);
		send_cmd(OP_TICK, 2'd0, 3'b000);
		send_cmd(OP_TICK, 2'd0, 3'b001);

		// A zero budget keeps the car parked.
		set_floor_steps(15'd0);
		send_cmd(OP_MOVE, 2'd2, 3'b000);
		send_cmd(OP_TICK, 2'd2, 3'b010);

		// One step per floor: the budget runs out before any sensor lights.
		set_floor_steps(15'd1);
		send_cmd(OP_MOVE, 2'd2, 3'b000);
		send_cmd(OP_TICK, 2'd0, 3'b000);
		send_cmd(OP_MOVE, 2'd3, 3'b000);
		send_cmd(OP_TICK, 2'd0, 3'b000);
		send_cmd(OP_TICK, 2'd0, 3'b000);

		// Largest budget over two floors, ended by the sensors.
		set_floor_steps(15'h7FFF);
		send_cmd(OP_MOVE, 2'd3, 3'b000);
		send_cmd(OP_TICK, 2'd0, 3'b000);
		send_cmd(OP_TICK, 2'd0, 3'b100);
		send_cmd(OP_MOVE, 2'd1, 3'b000);
		send_cmd(OP_TICK, 2'd0, 3'b001);

		// Random trips under several budgets; the first phase never idles.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: spf = SPF_W'($urandom_range(1, 4));
				1: spf = 15'd1;
				2: spf = 15'd2;
				3: spf = 15'd0;
				4: spf = 15'h7FFF;
				5: spf = SPF_W'($urandom_range(0, 32767));
				6: spf = SPF_W'($urandom_range(3, 8));
				default: spf = SPF_W'($urandom_range(1, 6));
			endcase
			set_floor_steps(spf);
			steady = (p == 0);
			quota  = (p == 3) ? 20 : 80;
			count  = 0;
			while (count < quota) begin
				run_trip(sent);
				count = count + sent;
			end
			steady = 1'b0;
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (!sb.failed && sb.pending() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule
